### hw/rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared constants, the sideband type and the saturation helper of the
// source-type plot transform.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int DIV_W      = 30;
    localparam int DEN_W      = 16;
    localparam int DIV_STAGES = DIV_W;

    typedef struct packed {
        logic               oor;
        logic               kneg;
        logic               tneg;
        logic               opp;
        logic               den_bad;
        logic [14:0]        at;
        logic [14:0]        p;
        logic [14:0]        ak;
        logic signed [15:0] k;
    } stp_side_t;

    function automatic logic signed [15:0] stp_sat(input logic neg, input logic [29:0] mag);
        logic signed [15:0] r;
        if (neg) begin
            if (mag >= 30'd32768) begin
                r = 16'sh8000;
            end else begin
                r = 16'(30'd0 - mag);
            end
        end else begin
            if (mag >= 30'd32768) begin
                r = 16'sh7fff;
            end else begin
                r = mag[15:0];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/source_type_plot_transform_top.sv
// ----------------------------------------------------------------------------
// source_type_plot_transform_top
// Maps a (tau, k) point to source-type plot coordinates (x, y).
//
//   Channel   Handshake               Word
//   input     in_valid / in_ready     tau_in, kappa_in
//   output    out_valid / out_ready   x_out, y_out, out_of_range
//
// One word is accepted per cycle while the output is not stalled. The
// pipeline has two front stages, thirty divider stages (one quotient bit
// each) and two back stages. Reset clears only the valid bits of every stage.
// Each stage holds its word under a stall and takes a new one as soon as the
// stage after it moves, so bubbles close up and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module source_type_plot_transform_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] tau_in,
    input  wire logic signed [15:0] kappa_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      x_out,
    output logic signed [15:0]      y_out,
    output logic                    out_of_range
);
    import stp_pkg::*;

    logic             f_valid, f_ready, d_valid, d_ready;
    logic [DIV_W-1:0] num_a, num_b, q_a, q_b;
    logic [DEN_W-1:0] den_a, den_b;
    stp_side_t        f_side, d_side;

    stp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tau_in    (tau_in),
        .kappa_in  (kappa_in),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .side      (f_side)
    );

    stp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .side_in   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .q_a       (q_a),
        .q_b       (q_b),
        .side_out  (d_side)
    );

    stp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (d_valid),
        .in_ready     (d_ready),
        .q_a          (q_a),
        .q_b          (q_b),
        .side         (d_side),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_out        (x_out),
        .y_out        (y_out),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

### hw/rtl/stp_front.sv
// ----------------------------------------------------------------------------
// stp_front
// Range check, quadrant decode, first product and divider operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [15:0]   tau_in,
    input  wire logic signed [15:0]   kappa_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [stp_pkg::DIV_W-1:0] num_a,
    output logic [stp_pkg::DEN_W-1:0] den_a,
    output logic [stp_pkg::DIV_W-1:0] num_b,
    output logic [stp_pkg::DEN_W-1:0] den_b,
    output stp_pkg::stp_side_t        side
);
    import stp_pkg::*;

    logic        v1_reg, v2_reg;
    logic        en1, en2;
    logic [16:0] at_w, ak_w;
    logic        corner_w, tneg_w, tpos_w, kneg_w, kpos_w;
    logic [14:0] at_eff, omk;
    stp_side_t   side1_next, side1_reg, side2_next, side2_reg;
    logic [29:0] prod_next, prod_reg;
    logic [15:0] den2_next, den2_reg;
    logic [14:0] p_w;
    logic [DIV_W-1:0] num_a_next, num_a_reg, num_b_next, num_b_reg;
    logic [DEN_W-1:0] den_a_next, den_a_reg, den_b_next, den_b_reg;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        at_w     = tau_in[15] ? (17'd0 - {1'b1, tau_in}) : {1'b0, tau_in};
        ak_w     = kappa_in[15] ? (17'd0 - {1'b1, kappa_in}) : {1'b0, kappa_in};
        corner_w = (at_w == 17'(ONE)) && (ak_w == 17'(ONE));
        at_eff   = corner_w ? 15'd0 : at_w[14:0];
        tneg_w   = tau_in[15] && !corner_w;
        tpos_w   = !tau_in[15] && (tau_in != 16'sd0) && !corner_w;
        kneg_w   = kappa_in[15];
        kpos_w   = !kappa_in[15] && (kappa_in != 16'sd0);
        omk      = 15'(ONE) - ak_w[14:0];
        prod_next = 30'(at_eff) * 30'(omk);
        den2_next = 16'(ONE) - {ak_w[14:0], 1'b0};
        side1_next.oor     = (at_w > 17'(ONE)) || (ak_w > 17'(ONE));
        side1_next.kneg    = kneg_w;
        side1_next.tneg    = tneg_w;
        side1_next.opp     = (!kneg_w && !tpos_w) || (!kpos_w && !tneg_w);
        side1_next.den_bad = ak_w[14:0] >= 15'(ONE / 2);
        side1_next.at      = at_eff;
        side1_next.p       = 15'd0;
        side1_next.ak      = ak_w[14:0];
        side1_next.k       = kappa_in;
    end

    always_comb
    begin
        p_w          = prod_reg[28:14];
        num_a_next   = {p_w, 15'd0};
        den_a_next   = 16'h8000 - {1'b0, p_w};
        num_b_next   = {1'b0, side1_reg.ak, 14'd0};
        den_b_next   = side1_reg.den_bad ? 16'd1 : den2_reg;
        side2_next   = side1_reg;
        side2_next.p = p_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            prod_reg  <= prod_next;
            den2_reg  <= den2_next;
            side1_reg <= side1_next;
        end
        if (en2 && v1_reg)
        begin
            num_a_reg <= num_a_next;
            den_a_reg <= den_a_next;
            num_b_reg <= num_b_next;
            den_b_reg <= den_b_next;
            side2_reg <= side2_next;
        end
    end

    assign out_valid = v2_reg;
    assign num_a     = num_a_reg;
    assign den_a     = den_a_reg;
    assign num_b     = num_b_reg;
    assign den_b     = den_b_reg;
    assign side      = side2_reg;

endmodule

`default_nettype wire

### hw/rtl/stp_div.sv
// ----------------------------------------------------------------------------
// stp_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [stp_pkg::DIV_W-1:0] num_a,
    input  wire logic [stp_pkg::DEN_W-1:0] den_a,
    input  wire logic [stp_pkg::DIV_W-1:0] num_b,
    input  wire logic [stp_pkg::DEN_W-1:0] den_b,
    input  wire stp_pkg::stp_side_t        side_in,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [stp_pkg::DIV_W-1:0]      q_a,
    output logic [stp_pkg::DIV_W-1:0]      q_b,
    output stp_pkg::stp_side_t             side_out
);
    import stp_pkg::*;

    logic [DIV_STAGES-1:0] v_reg;
    logic [DIV_STAGES:0]   en;
    logic [DEN_W-1:0] rema_reg [DIV_STAGES];
    logic [DEN_W-1:0] remb_reg [DIV_STAGES];
    logic [DIV_W-1:0] wa_reg   [DIV_STAGES];
    logic [DIV_W-1:0] wb_reg   [DIV_STAGES];
    logic [DEN_W-1:0] dena_reg [DIV_STAGES];
    logic [DEN_W-1:0] denb_reg [DIV_STAGES];
    stp_side_t        side_reg [DIV_STAGES];

    function automatic logic [DEN_W+DIV_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                        input logic [DIV_W-1:0] w,
                                                        input logic [DEN_W-1:0] den);
        logic [DEN_W:0]   cand;
        logic             ge;
        logic [DEN_W:0]   r;
        cand = {rem, w[DIV_W-1]};
        ge   = cand >= {1'b0, den};
        r    = ge ? (cand - {1'b0, den}) : cand;
        return {r[DEN_W-1:0], w[DIV_W-2:0], ge};
    endfunction

    assign en[DIV_STAGES] = out_ready;
    assign in_ready       = en[0];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic                   v_src;
            logic [DEN_W-1:0]       rema_src, remb_src, dena_src, denb_src;
            logic [DIV_W-1:0]       wa_src, wb_src;
            stp_side_t              side_src;
            logic [DEN_W+DIV_W-1:0] sa_next, sb_next;

            if (s == 0)
            begin : g_first
                assign v_src    = in_valid;
                assign rema_src = '0;
                assign remb_src = '0;
                assign wa_src   = num_a;
                assign wb_src   = num_b;
                assign dena_src = den_a;
                assign denb_src = den_b;
                assign side_src = side_in;
            end
            else
            begin : g_rest
                assign v_src    = v_reg[s-1];
                assign rema_src = rema_reg[s-1];
                assign remb_src = remb_reg[s-1];
                assign wa_src   = wa_reg[s-1];
                assign wb_src   = wb_reg[s-1];
                assign dena_src = dena_reg[s-1];
                assign denb_src = denb_reg[s-1];
                assign side_src = side_reg[s-1];
            end

            assign en[s]   = !v_reg[s] || en[s+1];
            assign sa_next = div_step(rema_src, wa_src, dena_src);
            assign sb_next = div_step(remb_src, wb_src, denb_src);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en[s])
                begin
                    v_reg[s] <= v_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[s] && v_src)
                begin
                    rema_reg[s] <= sa_next[DEN_W+DIV_W-1:DIV_W];
                    wa_reg[s]   <= sa_next[DIV_W-1:0];
                    remb_reg[s] <= sb_next[DEN_W+DIV_W-1:DIV_W];
                    wb_reg[s]   <= sb_next[DIV_W-1:0];
                    dena_reg[s] <= dena_src;
                    denb_reg[s] <= denb_src;
                    side_reg[s] <= side_src;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DIV_STAGES-1];
    assign q_a       = wa_reg[DIV_STAGES-1];
    assign q_b       = wb_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/stp_back.sv
// ----------------------------------------------------------------------------
// stp_back
// Second products, branch selection, sign and saturation of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [stp_pkg::DIV_W-1:0] q_a,
    input  wire logic [stp_pkg::DIV_W-1:0] q_b,
    input  wire stp_pkg::stp_side_t        side,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [15:0]             x_out,
    output logic signed [15:0]             y_out,
    output logic                           out_of_range
);
    import stp_pkg::*;

    logic        v1_reg, v2_reg, en1, en2;
    logic [31:0] prod_y_next, prod_y_reg;
    logic [43:0] prod_x_next, prod_x_reg;
    logic [16:0] ax_reg;
    logic [27:0] ayalt_reg;
    stp_side_t   side_reg;
    logic [16:0] ay_w;
    logic [29:0] xalt_w;
    logic        alt_w;
    logic signed [15:0] x_next, x_reg, y_next, y_reg;
    logic        oor_reg;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign prod_y_next = 32'(side.ak) * 32'(17'(2 * ONE) + q_a[16:0]);
    assign prod_x_next = 44'(side.at) * 44'(29'(ONE) + {1'b0, q_b[27:0]});

    always_comb
    begin
        ay_w   = prod_y_reg[31:15];
        xalt_w = prod_x_reg[43:14];
        alt_w  = {ay_w, 2'b00} < {2'b00, ax_reg};
        if (side_reg.oor)
        begin
            x_next = 16'sd0;
            y_next = 16'sd0;
        end
        else if (side_reg.opp)
        begin
            x_next = stp_sat(side_reg.tneg, 30'(side_reg.p));
            y_next = side_reg.k;
        end
        else if (alt_w)
        begin
            x_next = stp_sat(side_reg.kneg, side_reg.den_bad ? '1 : xalt_w);
            y_next = stp_sat(side_reg.kneg, side_reg.den_bad ? '1 : 30'(ayalt_reg));
        end
        else
        begin
            x_next = stp_sat(side_reg.kneg, 30'(ax_reg));
            y_next = stp_sat(side_reg.kneg, 30'(ay_w));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            prod_y_reg <= prod_y_next;
            prod_x_reg <= prod_x_next;
            ax_reg     <= q_a[16:0];
            ayalt_reg  <= q_b[27:0];
            side_reg   <= side;
        end
        if (en2 && v1_reg)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            oor_reg <= side_reg.oor;
        end
    end

    assign out_valid    = v2_reg;
    assign x_out        = x_reg;
    assign y_out        = y_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

### hw/rtl/stp_checker.sv
// ----------------------------------------------------------------------------
// stp_checker
// Port-level checks of the source-type plot transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] x_out,
    input wire logic signed [15:0] y_out,
    input wire logic               out_of_range
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out)
            && $stable(out_of_range))
        else $error("output word changed under a stall");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> (x_out == 16'sd0) && (y_out == 16'sd0))
        else $error("out of range word carries nonzero coordinates");

    a_sat_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_of_range && (x_out == 16'sh8000) |-> y_out[15])
        else $error("negative saturated x with nonnegative y");

    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while the output drains");

endmodule

bind source_type_plot_transform_top stp_checker u_stp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .x_out        (x_out),
    .y_out        (y_out),
    .out_of_range (out_of_range)
);

`default_nettype wire

### test/source_type_plot_transform_top_test.sv
// ----------------------------------------------------------------------------
// source_type_plot_transform_top_test
// Drives (tau, k) points into the source-type plot transform with random
// gaps on both sides, comparing each plot word to a local model or fixed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_type_plot_transform_top_test;

    localparam int LATENCY   = 34;
    localparam int N_RANDOM  = 650;
    localparam int MAX_CYCLES = 400000;
    localparam logic signed [15:0] Q_ONE = 16'sd16384;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               oor;
    } plot_word_t;

    typedef struct {
        logic signed [15:0] tau;
        logic signed [15:0] kappa;
        logic               fixed;
        plot_word_t         want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] tau_in;
    logic signed [15:0] kappa_in;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic out_of_range;

    plot_word_t plot_queue[$];
    int errors;
    int cycles;
    bit hold_off;
    bit sending_done;

    source_type_plot_transform_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tau_in       (tau_in),
        .kappa_in     (kappa_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_out        (x_out),
        .y_out        (y_out),
        .out_of_range (out_of_range)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
        begin
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic plot_word_t hudson_map(input logic signed [15:0] tau,
                                              input logic signed [15:0] kappa);
        longint one;
        longint t;
        longint k;
        longint at;
        longint ak;
        longint x;
        longint y;
        longint p;
        longint ax;
        longint ay;
        longint den;
        plot_word_t r;
        one = 64'sd16384;
        t = tau;
        k = kappa;
        at = t < 0 ? -t : t;
        ak = k < 0 ? -k : k;
        if (at > one || ak > one)
        begin
            r.x = '0;
            r.y = '0;
            r.oor = 1'b1;
            return r;
        end
        if (at == one && ak == one)
        begin
            t = 0;
            at = 0;
        end
        if ((k >= 0 && t <= 0) || (k <= 0 && t >= 0))
        begin
            x = t * (one - ak) / one;
            y = k;
        end
        else
        begin
            p = at * (one - ak) / one;
            ax = 2 * p * one / (2 * one - p);
            ay = ak * (2 * one + ax) / (2 * one);
            if (4 * ay < ax)
            begin
                den = one - 2 * ak;
                if (den > 0)
                begin
                    ay = ak * one / den;
                end
                else
                begin
                    ay = 64'sd1 << 40;
                end
                y = k < 0 ? -ay : ay;
                x = t * (one + ay) / one;
            end
            else
            begin
                x = k < 0 ? -ax : ax;
                y = k < 0 ? -ay : ay;
            end
        end
        r.x = clamp16(x);
        r.y = clamp16(y);
        r.oor = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("plot word mismatch on %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    task automatic idle_gap(input int long_pct);
        int n;
        if ($urandom_range(99) < long_pct)
        begin
            n = $urandom_range(60, 20);
        end
        else if ($urandom_range(1))
        begin
            n = 0;
        end
        else
        begin
            n = $urandom_range(3, 1);
        end
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_point(input logic signed [15:0] tau, input logic signed [15:0] kappa,
                              input plot_word_t want);
        in_valid <= 1'b1;
        tau_in <= tau;
        kappa_in <= kappa;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        plot_queue.push_back(want);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 80)
        begin
            return 16'($signed($urandom_range(32768)) - 16384);
        end
        else if (r < 90)
        begin
            return 16'($urandom);
        end
        else
        begin
            case ($urandom_range(5))
                0: return Q_ONE;
                1: return -Q_ONE;
                2: return 16'sd0;
                3: return 16'($signed($urandom_range(700)) - 350);
                4: return 16'($signed($urandom_range(8192, 7000)) * ($urandom_range(1) ? 1 : -1));
                default: return 16'($signed($urandom_range(16384, 16000)) * ($urandom_range(1) ? 1 : -1));
            endcase
        end
    endfunction

    // Rows marked fixed carry an expectation that is evident by inspection.
    stim_row_t directed[] = '{
        '{16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{16'sh7fff, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{16'sh8000, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{16'sd0, 16'sh7fff, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{16'sd0, 16'sh8000, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{16'sh8000, 16'sh7fff, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{16'sd16385, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{16'sd0, -16'sd16385, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{16'sd16384, 16'sd16384, 1'b1, '{16'sd0, 16'sd16384, 1'b0}},
        '{-16'sd16384, -16'sd16384, 1'b1, '{16'sd0, -16'sd16384, 1'b0}},
        '{16'sd16384, -16'sd16384, 1'b1, '{16'sd0, -16'sd16384, 1'b0}},
        '{-16'sd16384, 16'sd16384, 1'b1, '{16'sd0, 16'sd16384, 1'b0}},
        '{16'sd16384, 16'sd0, 1'b1, '{16'sd16384, 16'sd0, 1'b0}},
        '{-16'sd16384, 16'sd0, 1'b1, '{-16'sd16384, 16'sd0, 1'b0}},
        '{16'sd0, 16'sd16384, 1'b1, '{16'sd0, 16'sd16384, 1'b0}},
        '{16'sd8192, -16'sd4096, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{16'sd8192, 16'sd4096, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{16'sd16000, 16'sd100, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{-16'sd16000, -16'sd100, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{16'sd16384, 16'sd8191, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{-16'sd16384, -16'sd8192, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{16'sd1, 16'sd1, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{16'sd12000, 16'sd16383, 1'b0, '{16'sd0, 16'sd0, 1'b0}},
        '{-16'sd5555, -16'sd3000, 1'b0, '{16'sd0, 16'sd0, 1'b0}}
    };

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        tau_in = '0;
        kappa_in = '0;
        errors = 0;
        sending_done = 1'b0;
        hold_off = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed[i])
        begin
            send_point(directed[i].tau, directed[i].kappa,
                       directed[i].fixed ? directed[i].want
                                         : hudson_map(directed[i].tau, directed[i].kappa));
            idle_gap(5);
        end
        // A long receiver hold-off while words keep coming fills the pipeline.
        hold_off = 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            logic signed [15:0] t;
            logic signed [15:0] k;
            if (i == 120)
            begin
                hold_off = 1'b0;
            end
            if (i == 300)
            begin
                if (plot_queue.size() != 0)
                begin
                    in_valid <= 1'b0;
                    while (plot_queue.size() != 0)
                    begin
                        @(negedge clk);
                    end
                end
            end
            t = pick_coord();
            k = pick_coord();
            send_point(t, k, hudson_map(t, k));
            if (i % 50 > 30)
            begin
                idle_gap(3);
            end
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (150) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (cycles % 400 < 150)
            begin
                out_ready <= 1'b1;
            end
            else if ($urandom_range(99) < 4)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(40, 10)) @(negedge clk);
            end
            else
            begin
                out_ready <= $urandom_range(2) != 0;
            end
        end
    end

    always @(posedge clk)
    begin
        plot_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (plot_queue.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
            end
            else
            begin
                w = plot_queue.pop_front();
                if (x_out !== w.x)
                begin
                    report_mismatch("x_out", x_out, w.x);
                end
                if (y_out !== w.y)
                begin
                    report_mismatch("y_out", y_out, w.y);
                end
                if (out_of_range !== w.oor)
                begin
                    report_mismatch("out_of_range", out_of_range, w.oor);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > MAX_CYCLES)
            begin
                $display("source_type_plot_transform_top: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        wait (sending_done);
        while (plot_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * LATENCY) @(posedge clk);
        if (errors == 0)
        begin
            $display("source_type_plot_transform_top: match");
        end
        else
        begin
            $display("source_type_plot_transform_top: mismatch");
        end
        $finish;
    end

endmodule
